// ===== sv/rtld_pkg.sv =====
package rtld_pkg;

   localparam int FRAC_BITS = 28;
   localparam int MAX_STEPS = 5;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int DIV_W     = 32 + FRAC_BITS;
   localparam int DCNT_W    = $clog2(DIV_W);

   localparam logic signed [31:0] Q_ONE  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] Q_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic [63:0] TOL_SQ =
      ((64'd1 << (2 * FRAC_BITS)) + 64'd9999999999999999) / 64'd10000000000000000;

   localparam int NUM_CFG = 4;
   localparam logic [1:0] CSR_K1 = 2'd0;
   localparam logic [1:0] CSR_K2 = 2'd1;
   localparam logic [1:0] CSR_P1 = 2'd2;
   localparam logic [1:0] CSR_P2 = 2'd3;

   typedef enum logic [3:0] {
      OP_MUL, OP_QK, OP_ADD, OP_SUB, OP_DIV, OP_SQ0, OP_SQ1, OP_OUT,
      OP_BUND, OP_BZ, OP_BCONV, OP_LOOP, OP_CLRSTEP, OP_CALL, OP_RET, OP_DONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] dst;
      logic [5:0] a;
      logic [5:0] b;
      logic [7:0] tgt;
   } uop_type;

   // operand codes: bit 5 clear selects the scratch file
   localparam logic [5:0] R_EX   = 6'd0;
   localparam logic [5:0] R_EY   = 6'd1;
   localparam logic [5:0] R_D0   = 6'd2;
   localparam logic [5:0] R_D1   = 6'd3;
   localparam logic [5:0] R_F0   = 6'd4;
   localparam logic [5:0] R_F1   = 6'd5;
   localparam logic [5:0] R_F2   = 6'd6;
   localparam logic [5:0] R_E0   = 6'd7;
   localparam logic [5:0] R_E1   = 6'd8;
   localparam logic [5:0] R_T00  = 6'd9;
   localparam logic [5:0] R_T01  = 6'd10;
   localparam logic [5:0] R_T11  = 6'd11;
   localparam logic [5:0] R_G0   = 6'd12;
   localparam logic [5:0] R_G1   = 6'd13;
   localparam logic [5:0] R_DET  = 6'd14;
   localparam logic [5:0] R_TA   = 6'd15;
   localparam logic [5:0] R_TB   = 6'd16;
   localparam logic [5:0] R_XX   = 6'd17;
   localparam logic [5:0] R_YY   = 6'd18;
   localparam logic [5:0] R_XY   = 6'd19;
   localparam logic [5:0] R_R2   = 6'd20;
   localparam logic [5:0] R_K2R2 = 6'd21;
   localparam logic [5:0] R_T1   = 6'd22;
   localparam logic [5:0] R_T2   = 6'd23;
   localparam logic [5:0] R_RAD  = 6'd24;
   localparam logic [5:0] R_BASE = 6'd25;
   localparam logic [5:0] S_ZERO = 6'd32;
   localparam logic [5:0] S_ONE  = 6'd33;
   localparam logic [5:0] S_K1   = 6'd34;
   localparam logic [5:0] S_K2   = 6'd35;
   localparam logic [5:0] S_P1   = 6'd36;
   localparam logic [5:0] S_P2   = 6'd37;
   localparam logic [5:0] S_X    = 6'd38;
   localparam logic [5:0] S_Y    = 6'd39;
   localparam logic [5:0] S_C2   = 6'd40;
   localparam logic [5:0] S_C4   = 6'd41;
   localparam logic [5:0] S_C6   = 6'd42;

   localparam logic [7:0] L_UND  = 8'd10;
   localparam logic [7:0] L_LOOP = 8'd13;
   localparam logic [7:0] L_NEXT = 8'd48;
   localparam logic [7:0] L_FIN  = 8'd49;
   localparam logic [7:0] L_SING = 8'd64;
   localparam logic [7:0] L_DIST = 8'd68;

   localparam logic [7:0] O_RX  = 8'd0;
   localparam logic [7:0] O_RY  = 8'd1;
   localparam logic [7:0] O_JXX = 8'd2;
   localparam logic [7:0] O_JXY = 8'd3;
   localparam logic [7:0] O_JYY = 8'd4;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic uop_type mk(input op_type op, input logic [5:0] dst,
                                  input logic [5:0] a, input logic [5:0] b,
                                  input logic [7:0] tgt);
      uop_type u;
      u.op  = op;
      u.dst = dst[4:0];
      u.a   = a;
      u.b   = b;
      u.tgt = tgt;
      return u;
   endfunction

   function automatic uop_type a3(input op_type op, input logic [5:0] d,
                                  input logic [5:0] a, input logic [5:0] b);
      return mk(op, d, a, b, 8'd0);
   endfunction

   function automatic uop_type uop_rom(input logic [7:0] pc);
      uop_type u;
      case (pc)
         8'd0:   u = mk(OP_BUND, R_EX, S_ZERO, S_ZERO, L_UND);
         8'd1:   u = a3(OP_ADD, R_EX, S_X, S_ZERO);
         8'd2:   u = a3(OP_ADD, R_EY, S_Y, S_ZERO);
         8'd3:   u = mk(OP_CALL, R_EX, S_ZERO, S_ZERO, L_DIST);
         8'd4:   u = mk(OP_OUT, R_EX, R_D0, S_ZERO, O_RX);
         8'd5:   u = mk(OP_OUT, R_EX, R_D1, S_ZERO, O_RY);
         8'd6:   u = mk(OP_OUT, R_EX, R_F0, S_ZERO, O_JXX);
         8'd7:   u = mk(OP_OUT, R_EX, R_F1, S_ZERO, O_JXY);
         8'd8:   u = mk(OP_OUT, R_EX, R_F2, S_ZERO, O_JYY);
         8'd9:   u = a3(OP_DONE, R_EX, S_ZERO, S_ZERO);
         8'd10:  u = a3(OP_ADD, R_EX, S_X, S_ZERO);
         8'd11:  u = a3(OP_ADD, R_EY, S_Y, S_ZERO);
         8'd12:  u = a3(OP_CLRSTEP, R_EX, S_ZERO, S_ZERO);
         8'd13:  u = mk(OP_CALL, R_EX, S_ZERO, S_ZERO, L_DIST);
         8'd14:  u = a3(OP_SUB, R_E0, S_X, R_D0);
         8'd15:  u = a3(OP_SUB, R_E1, S_Y, R_D1);
         8'd16:  u = a3(OP_MUL, R_TA, R_F0, R_F0);
         8'd17:  u = a3(OP_MUL, R_TB, R_F1, R_F1);
         8'd18:  u = a3(OP_ADD, R_T00, R_TA, R_TB);
         8'd19:  u = a3(OP_MUL, R_TA, R_F0, R_F1);
         8'd20:  u = a3(OP_MUL, R_TB, R_F1, R_F2);
         8'd21:  u = a3(OP_ADD, R_T01, R_TA, R_TB);
         8'd22:  u = a3(OP_MUL, R_TA, R_F1, R_F1);
         8'd23:  u = a3(OP_MUL, R_TB, R_F2, R_F2);
         8'd24:  u = a3(OP_ADD, R_T11, R_TA, R_TB);
         8'd25:  u = a3(OP_MUL, R_TA, R_F0, R_E0);
         8'd26:  u = a3(OP_MUL, R_TB, R_F1, R_E1);
         8'd27:  u = a3(OP_ADD, R_G0, R_TA, R_TB);
         8'd28:  u = a3(OP_MUL, R_TA, R_F1, R_E0);
         8'd29:  u = a3(OP_MUL, R_TB, R_F2, R_E1);
         8'd30:  u = a3(OP_ADD, R_G1, R_TA, R_TB);
         8'd31:  u = a3(OP_MUL, R_TA, R_T00, R_T11);
         8'd32:  u = a3(OP_MUL, R_TB, R_T01, R_T01);
         8'd33:  u = a3(OP_SUB, R_DET, R_TA, R_TB);
         8'd34:  u = mk(OP_BZ, R_EX, R_DET, S_ZERO, L_NEXT);
         8'd35:  u = a3(OP_MUL, R_TA, R_T11, R_G0);
         8'd36:  u = a3(OP_MUL, R_TB, R_T01, R_G1);
         8'd37:  u = a3(OP_SUB, R_TA, R_TA, R_TB);
         8'd38:  u = a3(OP_DIV, R_TA, R_TA, R_DET);
         8'd39:  u = a3(OP_ADD, R_EX, R_EX, R_TA);
         8'd40:  u = a3(OP_MUL, R_TA, R_T00, R_G1);
         8'd41:  u = a3(OP_MUL, R_TB, R_T01, R_G0);
         8'd42:  u = a3(OP_SUB, R_TA, R_TA, R_TB);
         8'd43:  u = a3(OP_DIV, R_TA, R_TA, R_DET);
         8'd44:  u = a3(OP_ADD, R_EY, R_EY, R_TA);
         8'd45:  u = a3(OP_SQ0, R_EX, R_E0, R_E0);
         8'd46:  u = a3(OP_SQ1, R_EX, R_E1, R_E1);
         8'd47:  u = mk(OP_BCONV, R_EX, S_ZERO, S_ZERO, L_FIN);
         8'd48:  u = mk(OP_LOOP, R_EX, S_ZERO, S_ZERO, L_LOOP);
         8'd49:  u = mk(OP_CALL, R_EX, S_ZERO, S_ZERO, L_DIST);
         8'd50:  u = a3(OP_MUL, R_TA, R_F0, R_F2);
         8'd51:  u = a3(OP_MUL, R_TB, R_F1, R_F1);
         8'd52:  u = a3(OP_SUB, R_DET, R_TA, R_TB);
         8'd53:  u = mk(OP_OUT, R_EX, R_EX, S_ZERO, O_RX);
         8'd54:  u = mk(OP_OUT, R_EX, R_EY, S_ZERO, O_RY);
         8'd55:  u = mk(OP_BZ, R_EX, R_DET, S_ZERO, L_SING);
         8'd56:  u = a3(OP_DIV, R_TA, R_F2, R_DET);
         8'd57:  u = mk(OP_OUT, R_EX, R_TA, S_ZERO, O_JXX);
         8'd58:  u = a3(OP_SUB, R_TB, S_ZERO, R_F1);
         8'd59:  u = a3(OP_DIV, R_TB, R_TB, R_DET);
         8'd60:  u = mk(OP_OUT, R_EX, R_TB, S_ZERO, O_JXY);
         8'd61:  u = a3(OP_DIV, R_TA, R_F0, R_DET);
         8'd62:  u = mk(OP_OUT, R_EX, R_TA, S_ZERO, O_JYY);
         8'd63:  u = a3(OP_DONE, R_EX, S_ZERO, S_ZERO);
         8'd64:  u = mk(OP_OUT, R_EX, R_F0, S_ZERO, O_JXX);
         8'd65:  u = mk(OP_OUT, R_EX, R_F1, S_ZERO, O_JXY);
         8'd66:  u = mk(OP_OUT, R_EX, R_F2, S_ZERO, O_JYY);
         8'd67:  u = a3(OP_DONE, R_EX, S_ZERO, S_ZERO);
         // distortion model and Jacobian at (EX, EY)
         8'd68:  u = a3(OP_MUL, R_XX, R_EX, R_EX);
         8'd69:  u = a3(OP_MUL, R_YY, R_EY, R_EY);
         8'd70:  u = a3(OP_MUL, R_XY, R_EX, R_EY);
         8'd71:  u = a3(OP_ADD, R_R2, R_XX, R_YY);
         8'd72:  u = a3(OP_MUL, R_K2R2, S_K2, R_R2);
         8'd73:  u = a3(OP_MUL, R_T1, S_K1, R_R2);
         8'd74:  u = a3(OP_MUL, R_T2, R_K2R2, R_R2);
         8'd75:  u = a3(OP_ADD, R_RAD, R_T1, R_T2);
         8'd76:  u = a3(OP_ADD, R_BASE, S_ONE, R_RAD);
         8'd77:  u = a3(OP_MUL, R_T1, R_EX, R_RAD);
         8'd78:  u = a3(OP_ADD, R_T1, R_EX, R_T1);
         8'd79:  u = a3(OP_MUL, R_T2, S_P1, R_XY);
         8'd80:  u = a3(OP_QK, R_T2, R_T2, S_C2);
         8'd81:  u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd82:  u = a3(OP_QK, R_T2, R_XX, S_C2);
         8'd83:  u = a3(OP_ADD, R_T2, R_R2, R_T2);
         8'd84:  u = a3(OP_MUL, R_T2, S_P2, R_T2);
         8'd85:  u = a3(OP_ADD, R_D0, R_T1, R_T2);
         8'd86:  u = a3(OP_MUL, R_T1, R_EY, R_RAD);
         8'd87:  u = a3(OP_ADD, R_T1, R_EY, R_T1);
         8'd88:  u = a3(OP_MUL, R_T2, S_P2, R_XY);
         8'd89:  u = a3(OP_QK, R_T2, R_T2, S_C2);
         8'd90:  u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd91:  u = a3(OP_QK, R_T2, R_YY, S_C2);
         8'd92:  u = a3(OP_ADD, R_T2, R_R2, R_T2);
         8'd93:  u = a3(OP_MUL, R_T2, S_P1, R_T2);
         8'd94:  u = a3(OP_ADD, R_D1, R_T1, R_T2);
         8'd95:  u = a3(OP_MUL, R_T1, S_K1, R_XX);
         8'd96:  u = a3(OP_QK, R_T1, R_T1, S_C2);
         8'd97:  u = a3(OP_ADD, R_T1, R_BASE, R_T1);
         8'd98:  u = a3(OP_MUL, R_T2, R_K2R2, R_XX);
         8'd99:  u = a3(OP_QK, R_T2, R_T2, S_C4);
         8'd100: u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd101: u = a3(OP_MUL, R_T2, S_P1, R_EY);
         8'd102: u = a3(OP_QK, R_T2, R_T2, S_C2);
         8'd103: u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd104: u = a3(OP_MUL, R_T2, S_P2, R_EX);
         8'd105: u = a3(OP_QK, R_T2, R_T2, S_C6);
         8'd106: u = a3(OP_ADD, R_F0, R_T1, R_T2);
         8'd107: u = a3(OP_MUL, R_T1, S_K1, R_XY);
         8'd108: u = a3(OP_QK, R_T1, R_T1, S_C2);
         8'd109: u = a3(OP_MUL, R_T2, R_K2R2, R_XY);
         8'd110: u = a3(OP_QK, R_T2, R_T2, S_C4);
         8'd111: u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd112: u = a3(OP_MUL, R_T2, S_P1, R_EX);
         8'd113: u = a3(OP_QK, R_T2, R_T2, S_C2);
         8'd114: u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd115: u = a3(OP_MUL, R_T2, S_P2, R_EY);
         8'd116: u = a3(OP_QK, R_T2, R_T2, S_C2);
         8'd117: u = a3(OP_ADD, R_F1, R_T1, R_T2);
         8'd118: u = a3(OP_MUL, R_T1, S_K1, R_YY);
         8'd119: u = a3(OP_QK, R_T1, R_T1, S_C2);
         8'd120: u = a3(OP_ADD, R_T1, R_BASE, R_T1);
         8'd121: u = a3(OP_MUL, R_T2, R_K2R2, R_YY);
         8'd122: u = a3(OP_QK, R_T2, R_T2, S_C4);
         8'd123: u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd124: u = a3(OP_MUL, R_T2, S_P1, R_EY);
         8'd125: u = a3(OP_QK, R_T2, R_T2, S_C6);
         8'd126: u = a3(OP_ADD, R_T1, R_T1, R_T2);
         8'd127: u = a3(OP_MUL, R_T2, S_P2, R_EX);
         8'd128: u = a3(OP_QK, R_T2, R_T2, S_C2);
         8'd129: u = a3(OP_ADD, R_F2, R_T1, R_T2);
         8'd130: u = a3(OP_RET, R_EX, S_ZERO, S_ZERO);
         default: u = a3(OP_DONE, R_EX, S_ZERO, S_ZERO);
      endcase
      return u;
   endfunction

endpackage

// ===== sv/radtan_lens_distortion_unit.sv =====
// Radial-tangential lens distortion unit. A req word carries a point of the
// normalized image plane (Q4.28) and an operation in req_tuser: 0 returns the
// distorted point with its symmetric Jacobian, 1 inverts the model by up to
// five Gauss-Newton steps and returns the point, a converged flag and the
// inverse Jacobian there, or the Jacobian itself where it is singular. One
// item is worked at a time by a microcoded sequencer around a scratch
// register file, one 32x32 multiplier/adder and a bit-serial divider.
// req_tready is high only between items; the last result is held in its own
// register, so the next item may start before it is taken.
// The k1, k2, p1, p2 coefficients are to be written over the csr port only
// while idle; the block itself does not enforce this.
module radtan_lens_distortion_unit
   import rtld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // point_x, point_y
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // result_x, result_y, jac_xx, jac_xy, jac_yy
   output logic         rsp_tuser,   // converged
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_WB    = 5'b01000,
      ST_DIV   = 5'b10000
   } state_type;

   state_type state_ff;
   logic [7:0] pc_ff, ret_ff;
   logic [STEP_W-1:0] step_ff;
   uop_type uop_ff;
   logic op_ff, conv_ff;
   logic signed [31:0] x_ff, y_ff, k1_ff, k2_ff, p1_ff, p2_ff;
   logic signed [31:0] rda_ff, rdb_ff;
   logic signed [31:0] mem [32];
   logic signed [63:0] acc_ff;
   logic [63:0] ss_ff;
   logic signed [31:0] stage_ff [5];
   logic [159:0] rsp_data_ff;
   logic rsp_valid_ff, rsp_conv_ff;
   logic [DIV_W-1:0] dnq_ff;
   logic [31:0] drem_ff, dden_ff;
   logic dneg_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   uop_type uop_in;
   logic signed [31:0] opa, opb, wb_val;
   logic signed [63:0] mag, rnd;
   logic [32:0] dt;
   logic dge;
   logic [31:0] drem_in;
   logic [DIV_W-1:0] dnq_in;
   logic [31:0] mag_a, mag_b;

   function automatic logic signed [31:0] pick(input logic [5:0] code,
                                               input logic signed [31:0] rd);
      case (code)
         S_ZERO:  return 32'sd0;
         S_ONE:   return Q_ONE;
         S_K1:    return k1_ff;
         S_K2:    return k2_ff;
         S_P1:    return p1_ff;
         S_P2:    return p2_ff;
         S_X:     return x_ff;
         S_Y:     return y_ff;
         S_C2:    return 32'sd2;
         S_C4:    return 32'sd4;
         S_C6:    return 32'sd6;
         default: return rd;
      endcase
   endfunction

   assign uop_in = uop_rom(pc_ff);

   always_comb begin
      opa = pick(uop_ff.a, rda_ff);
      opb = pick(uop_ff.b, rdb_ff);
   end

   assign mag_a = opa[31] ? 32'(-opa) : 32'(opa);
   assign mag_b = opb[31] ? 32'(-opb) : 32'(opb);

   assign dt      = {drem_ff, dnq_ff[DIV_W-1]};
   assign dge     = dt >= {1'b0, dden_ff};
   assign drem_in = dge ? 32'(dt - {1'b0, dden_ff}) : dt[31:0];
   assign dnq_in  = {dnq_ff[DIV_W-2:0], dge};

   always_comb begin
      mag = acc_ff[63] ? -acc_ff : acc_ff;
      rnd = (mag + Q_HALF) >>> FRAC_BITS;
      if (uop_ff.op == OP_MUL) begin
         wb_val = sat32(acc_ff[63] ? -rnd : rnd);
      end else begin
         wb_val = sat32(acc_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_conv_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         rda_ff <= mem[uop_in.a[4:0]];
         rdb_ff <= mem[uop_in.b[4:0]];
      end
      if (state_ff == ST_WB && uop_ff.op != OP_SQ0 && uop_ff.op != OP_SQ1) begin
         mem[uop_ff.dst] <= wb_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
         k1_ff        <= 32'sd0;
         k2_ff        <= 32'sd0;
         p1_ff        <= 32'sd0;
         p2_ff        <= 32'sd0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_K1:  k1_ff <= csr_data;
               CSR_K2:  k2_ff <= csr_data;
               CSR_P1:  p1_ff <= csr_data;
               CSR_P2:  p2_ff <= csr_data;
               default: k1_ff <= k1_ff;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser;
                  conv_ff  <= ~req_tuser;
                  x_ff     <= req_tdata[31:0];
                  y_ff     <= req_tdata[63:32];
                  pc_ff    <= 8'd0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               uop_ff   <= uop_in;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= ST_FETCH;
               pc_ff    <= pc_ff + 8'd1;
               unique case (uop_ff.op) inside
                  OP_MUL, OP_QK, OP_SQ0, OP_SQ1: begin
                     acc_ff   <= opa * opb;
                     state_ff <= ST_WB;
                     pc_ff    <= pc_ff;
                  end
                  OP_ADD: begin
                     acc_ff   <= 64'(opa) + 64'(opb);
                     state_ff <= ST_WB;
                     pc_ff    <= pc_ff;
                  end
                  OP_SUB: begin
                     acc_ff   <= 64'(opa) - 64'(opb);
                     state_ff <= ST_WB;
                     pc_ff    <= pc_ff;
                  end
                  OP_DIV: begin
                     dneg_ff  <= opa[31] ^ opb[31];
                     dnq_ff   <= {mag_a, {FRAC_BITS{1'b0}}};
                     dden_ff  <= mag_b;
                     drem_ff  <= 32'd0;
                     dcnt_ff  <= '0;
                     state_ff <= ST_DIV;
                     pc_ff    <= pc_ff;
                  end
                  OP_OUT: stage_ff[uop_ff.tgt[2:0]] <= opa;
                  OP_BUND: if (op_ff) pc_ff <= uop_ff.tgt;
                  OP_BZ: if (opa == 32'sd0) pc_ff <= uop_ff.tgt;
                  OP_BCONV: begin
                     if (ss_ff < TOL_SQ) begin
                        conv_ff <= 1'b1;
                        pc_ff   <= uop_ff.tgt;
                     end
                  end
                  OP_LOOP: begin
                     if (step_ff < STEP_W'(MAX_STEPS - 1)) begin
                        step_ff <= step_ff + 1'b1;
                        pc_ff   <= uop_ff.tgt;
                     end
                  end
                  OP_CLRSTEP: step_ff <= '0;
                  OP_CALL: begin
                     ret_ff <= pc_ff + 8'd1;
                     pc_ff  <= uop_ff.tgt;
                  end
                  OP_RET: pc_ff <= ret_ff;
                  OP_DONE: begin
                     if (!rsp_valid_ff || rsp_tready) begin
                        rsp_data_ff  <= {stage_ff[4], stage_ff[3], stage_ff[2],
                                         stage_ff[1], stage_ff[0]};
                        rsp_conv_ff  <= conv_ff;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        state_ff <= ST_EXEC;
                     end
                     pc_ff <= pc_ff;
                  end
                  default: pc_ff <= pc_ff + 8'd1;
               endcase
            end
            ST_DIV: begin
               drem_ff <= drem_in;
               dnq_ff  <= dnq_in;
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
                  acc_ff   <= dneg_ff ? -64'(dnq_in) : 64'(dnq_in);
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
               if (uop_ff.op == OP_SQ0) begin
                  ss_ff <= acc_ff;
               end else if (uop_ff.op == OP_SQ1) begin
                  ss_ff <= ss_ff + acc_ff;
               end
               pc_ff    <= pc_ff + 8'd1;
               state_ff <= ST_FETCH;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
